// File: design/sdfb_pkg.sv
`timescale 1ns / 1ps
package sdfb_pkg;

	localparam logic [7:0] STUFF_XOR = 8'h20;
	localparam int unsigned SEQ_SHIFT = 5;

	localparam logic [7:0] FLAG_RESET = 8'h7E;
	localparam logic [7:0] ESCAPE_RESET = 8'h7D;
	localparam logic [7:0] ADDRESS_RESET = 8'h03;
	localparam logic SEQ_RESET = 1'b0;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FLAG = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEQ = 2'd3;

	typedef struct packed {
		logic [7:0] flag;
		logic [7:0] escape;
		logic [7:0] address;
		logic       seq;
	} cfg_t;

	// one classified payload word handed from front to back
	typedef struct packed {
		logic       hdr;
		logic       last;
		logic [7:0] data;
		logic [7:0] check;
	} job_t;

	typedef enum logic [2:0] {
		SLOT_OPEN,
		SLOT_ADDR,
		SLOT_CTRL,
		SLOT_HCHK,
		SLOT_DATA,
		SLOT_PCHK,
		SLOT_CLOSE
	} slot_t;

endpackage

// File: design/sdfb_in_if.sv
`timescale 1ns / 1ps
interface sdfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       final_byte;

	modport source(output valid, output payload_byte, output final_byte, input ready);
	modport sink(input valid, input payload_byte, input final_byte, output ready);
endinterface

// File: design/sdfb_out_if.sv
`timescale 1ns / 1ps
interface sdfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       run_end;
	logic       frame_end;

	modport source(output valid, output line_byte, output run_end, output frame_end,
		input ready);
	modport sink(input valid, input line_byte, input run_end, input frame_end,
		output ready);
endinterface

// File: design/sdfb_front.sv
`timescale 1ns / 1ps
module sdfb_front (
	input  logic           clk,
	input  logic           arst_n,
	sdfb_in_if.sink        payload_ch,
	input  logic           q_full,
	output logic           q_push,
	output sdfb_pkg::job_t q_job
);
	import sdfb_pkg::*;

	logic       in_frame_q;
	logic [7:0] check_q;
	logic [7:0] check_next;
	logic       accept;

	assign payload_ch.ready = !q_full;
	assign accept = payload_ch.valid && !q_full;
	assign q_push = accept;

	// header goes out when no frame is open; check restarts with it
	assign check_next = (in_frame_q ? check_q : 8'h00) ^ payload_ch.payload_byte;

	always_comb begin
		q_job.hdr   = !in_frame_q;
		q_job.last  = payload_ch.final_byte;
		q_job.data  = payload_ch.payload_byte;
		q_job.check = check_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			check_q    <= 8'h00;
		end else if (accept) begin
			in_frame_q <= !payload_ch.final_byte;
			check_q    <= payload_ch.final_byte ? 8'h00 : check_next;
		end
	end
endmodule

// File: design/sdfb_queue.sv
`timescale 1ns / 1ps
module sdfb_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sdfb_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output sdfb_pkg::job_t head_job
);
	import sdfb_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign avail    = (count_q != '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: design/sdfb_back.sv
`timescale 1ns / 1ps
module sdfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sdfb_pkg::cfg_t cfg,
	input  logic           q_avail,
	input  sdfb_pkg::job_t job,
	output logic           q_pop,
	sdfb_out_if.source     line_ch
);
	import sdfb_pkg::*;

	slot_t      slot_q;
	logic       started_q;
	logic       phase_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_run_end_q;
	logic       out_frame_end_q;

	slot_t      cur_slot;
	slot_t      next_slot;
	logic [7:0] control;
	logic [7:0] value;
	logic       stuffable;
	logic       need_esc;
	logic [7:0] line_byte;
	logic       slot_done;
	logic       job_done;
	logic       step;

	assign control  = 8'({cfg.seq}) << SEQ_SHIFT;
	assign cur_slot = started_q ? slot_q : (job.hdr ? SLOT_OPEN : SLOT_DATA);

	always_comb begin
		value     = cfg.flag;
		stuffable = 1'b0;
		unique case (cur_slot)
			SLOT_OPEN:  begin value = cfg.flag;                 stuffable = 1'b0; end
			SLOT_ADDR:  begin value = cfg.address;              stuffable = 1'b1; end
			SLOT_CTRL:  begin value = control;                  stuffable = 1'b1; end
			SLOT_HCHK:  begin value = cfg.address ^ control;    stuffable = 1'b1; end
			SLOT_DATA:  begin value = job.data;                 stuffable = 1'b1; end
			SLOT_PCHK:  begin value = job.check;                stuffable = 1'b1; end
			SLOT_CLOSE: begin value = cfg.flag;                 stuffable = 1'b0; end
			default:    begin value = cfg.flag;                 stuffable = 1'b0; end
		endcase
	end

	// second half of a stuffed pair carries value ^ 0x20
	assign need_esc  = stuffable && ((value == cfg.flag) || (value == cfg.escape));
	assign line_byte = phase_q ? (value ^ STUFF_XOR) : (need_esc ? cfg.escape : value);
	assign slot_done = !need_esc || phase_q;
	assign job_done  = (cur_slot == SLOT_CLOSE) ||
		((cur_slot == SLOT_DATA) && !job.last && slot_done);

	always_comb begin
		next_slot = cur_slot;
		unique case (cur_slot)
			SLOT_OPEN:  next_slot = SLOT_ADDR;
			SLOT_ADDR:  next_slot = SLOT_CTRL;
			SLOT_CTRL:  next_slot = SLOT_HCHK;
			SLOT_HCHK:  next_slot = SLOT_DATA;
			SLOT_DATA:  next_slot = SLOT_PCHK;
			SLOT_PCHK:  next_slot = SLOT_CLOSE;
			SLOT_CLOSE: next_slot = SLOT_OPEN;
			default:    next_slot = SLOT_OPEN;
		endcase
	end

	assign step  = q_avail && (!out_valid_q || line_ch.ready);
	assign q_pop = step && job_done;

	assign line_ch.valid     = out_valid_q;
	assign line_ch.line_byte = out_byte_q;
	assign line_ch.run_end   = out_run_end_q;
	assign line_ch.frame_end = out_frame_end_q;

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q      <= line_byte;
			out_run_end_q   <= job_done;
			out_frame_end_q <= (cur_slot == SLOT_CLOSE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= SLOT_OPEN;
			started_q   <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			if (!slot_done) begin
				phase_q   <= 1'b1;
				started_q <= 1'b1;
				slot_q    <= cur_slot;
			end else begin
				phase_q   <= 1'b0;
				started_q <= !job_done;
				slot_q    <= next_slot;
			end
		end else if (line_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

// File: design/stuffed_data_frame_builder_unit.sv
`timescale 1ns / 1ps
// Byte-stuffing framer for data frames. Each accepted payload word is one raw
// byte plus a final_byte marker; the line side sends one line byte per cycle
// while a job is queued and the line side is ready. The first byte of a frame
// also produces the opening flag, address, control (seq bit at bit five) and
// header check; the final byte also produces the payload XOR check and the
// closing flag (frame_end set). Every byte between the flags that equals the
// flag or escape value goes out as escape then value ^ 0x20. run_end marks
// the last line byte caused by a payload word. Rate: the back sequencer emits
// one line byte per clock under the same conditions; a payload word costs 1
// or 2 line bytes, plus 4 to 7 for a header and 2 to 3 for a trailer. The
// front takes a word every cycle while the QUEUE_DEPTH job queue has room.
// Configuration writes are registered and must come while the block is idle.
module stuffed_data_frame_builder_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sdfb_in_if.sink                          payload_ch,
	sdfb_out_if.source                       line_ch,
	input  logic                             cfg_we,
	input  logic [sdfb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);
	import sdfb_pkg::*;

	cfg_t       cfg_q;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_avail;
	job_t       push_job;
	job_t       head_job;

	// register file: unknown indexes cannot occur with a 2-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag    <= FLAG_RESET;
			cfg_q.escape  <= ESCAPE_RESET;
			cfg_q.address <= ADDRESS_RESET;
			cfg_q.seq     <= SEQ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLAG:    cfg_q.flag    <= cfg_data;
				CFG_ESCAPE:  cfg_q.escape  <= cfg_data;
				CFG_ADDRESS: cfg_q.address <= cfg_data;
				CFG_SEQ:     cfg_q.seq     <= cfg_data[0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// front: accept and classify, keep frame state and running check
	sdfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload_ch (payload_ch),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	// decoupling queue of classified words
	sdfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head_job (head_job)
	);

	// back: slot sequencer, stuffing and output register
	sdfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_avail (q_avail),
		.job     (head_job),
		.q_pop   (q_pop),
		.line_ch (line_ch)
	);
endmodule

// File: design/sdfb_checker.sv
`timescale 1ns / 1ps
module sdfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] line_byte,
	input logic       run_end,
	input logic       frame_end
);
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("line word dropped while stalled");

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(line_byte) && $stable(run_end))
		else $error("line word changed while stalled");

	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_end)
		else $error("closing flag not last word of its run");

	a_no_double_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
		else $error("two closing flags in a row");
endmodule

bind stuffed_data_frame_builder_unit sdfb_checker u_sdfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (line_ch.valid),
	.out_ready (line_ch.ready),
	.line_byte (line_ch.line_byte),
	.run_end   (line_ch.run_end),
	.frame_end (line_ch.frame_end)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import sdfb_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000; // cycles with no word moving on either side
	localparam int unsigned DRAIN_TAIL = 8;     // room for a header of up to 7 line bytes
	localparam int unsigned HOLD_CYCLES = 80;   // long line-side stall to back up the queue
	localparam logic [7:0] STUFF_MASK = 8'h20;

	// one expected line word
	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_end;
		logic       frame_end;
	} line_word_t;

	// Framer predictor plus expected-word store. Register copies are updated at the
	// same edge the block sees the write.
	class frame_scoreboard;
		logic [7:0] line_flag;
		logic [7:0] line_escape;
		logic [7:0] frame_address;
		logic       frame_seq;
		logic       hdr_sent;
		logic [7:0] payload_xor;
		line_word_t run_buf[12];
		int         run_len;
		line_word_t expected_q[$];
		int         errors;

		function new();
			line_flag = 8'h7E;
			line_escape = 8'h7D;
			frame_address = 8'h03;
			frame_seq = 1'b0;
			hdr_sent = 1'b0;
			payload_xor = 8'h00;
			run_len = 0;
			errors = 0;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR at %0t ns: %s", $time, msg);
		endtask

		function void write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
			case (idx)
				CFG_FLAG: line_flag = val;
				CFG_ESCAPE: line_escape = val;
				CFG_ADDRESS: frame_address = val;
				CFG_SEQ: frame_seq = val[0];
				default: ;
			endcase
		endfunction

		function void add_word(input logic [7:0] b, input logic closing);
			run_buf[run_len] = '{line_byte: b, run_end: 1'b0, frame_end: closing};
			run_len++;
		endfunction

		// flag or escape between the delimiters goes out as escape, value ^ 0x20
		function void add_stuffed(input logic [7:0] b);
			if (b == line_flag || b == line_escape) begin
				add_word(line_escape, 1'b0);
				add_word(b ^ STUFF_MASK, 1'b0);
			end else begin
				add_word(b, 1'b0);
			end
		endfunction

		function void note_payload(input logic [7:0] data, input logic last);
			logic [7:0] ctrl;
			run_len = 0;
			if (!hdr_sent) begin
				ctrl = {2'b00, frame_seq, 5'b00000};
				add_word(line_flag, 1'b0);
				add_stuffed(frame_address);
				add_stuffed(ctrl);
				add_stuffed(frame_address ^ ctrl);
				hdr_sent = 1'b1;
				payload_xor = 8'h00;
			end
			add_stuffed(data);
			payload_xor ^= data;
			if (last) begin
				add_stuffed(payload_xor);
				add_word(line_flag, 1'b1);
				hdr_sent = 1'b0;
				payload_xor = 8'h00;
			end
			run_buf[run_len-1].run_end = 1'b1;
			for (int i = 0; i < run_len; i++)
				expected_q.push_back(run_buf[i]);
		endfunction

		task check_line(input logic [7:0] b, input logic re, input logic fe);
			line_word_t exp_word;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected line word %02h run_end=%0b frame_end=%0b", b, re, fe));
			end else begin
				exp_word = expected_q.pop_front();
				if (b !== exp_word.line_byte)
					report($sformatf("line_byte %02h, want %02h", b, exp_word.line_byte));
				if (re !== exp_word.run_end)
					report($sformatf("run_end %0b, want %0b (byte %02h)", re, exp_word.run_end, b));
				if (fe !== exp_word.frame_end)
					report($sformatf("frame_end %0b, want %0b (byte %02h)", fe, exp_word.frame_end, b));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	sdfb_in_if  in_ch();
	sdfb_out_if out_ch();

	// idle knobs, flipped per phase
	logic send_idle;
	logic recv_idle;
	logic hold_req;

	int unsigned stall_cycles;
	int          frame_left;

	frame_scoreboard sb;

	stuffed_data_frame_builder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.payload_ch(in_ch),
		.line_ch   (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Monitor: register writes, accepted payload words and accepted line words
	// are all handled in one block so prediction always lands before the check
	// when both happen on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_ch.valid && in_ch.ready)
				sb.note_payload(in_ch.payload_byte, in_ch.final_byte);
			if (out_ch.valid && out_ch.ready)
				sb.check_line(out_ch.line_byte, out_ch.run_end, out_ch.frame_end);
		end
	end

	// Watchdog: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Line side: random stall per word, plus an optional long hold-off that
	// lets the job queue fill and push back on the payload side.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = recv_idle ? $urandom_range(0, 4) : 0;
			repeat (gap) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Offer one payload word and hold it until the handshake.
	task automatic send_payload(input logic [7:0] data, input logic last);
		int gap;
		gap = send_idle ? $urandom_range(0, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.payload_byte <= data;
		in_ch.final_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Block is idle once nothing is pending; first step off the edge so the
	// monitor has already booked the last accepted payload word.
	task automatic wait_drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// seq register only keeps bit 0; junk in the upper bits must be dropped
	task automatic set_config(input logic [7:0] flag, input logic [7:0] esc,
		input logic [7:0] addr, input logic seq);
		write_reg(CFG_FLAG, flag);
		write_reg(CFG_ESCAPE, esc);
		write_reg(CFG_ADDRESS, addr);
		write_reg(CFG_SEQ, {7'($urandom), seq});
	endtask

	// Payload bytes leaning toward the stuffed values
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return sb.line_flag;
			1: return sb.line_escape;
			2: return sb.line_flag ^ STUFF_MASK;
			default: return 8'($urandom);
		endcase
	endfunction

	// Random frames; a frame left open carries over into the next phase.
	task automatic send_frames(input int n_words);
		for (int i = 0; i < n_words; i++) begin
			if (frame_left == 0)
				frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(1, 6);
			frame_left--;
			send_payload(pick_byte(), frame_left == 0);
		end
	endtask

	initial begin
		logic [7:0] r;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload_byte = 8'h00;
		in_ch.final_byte = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FLAG;
		cfg_data = 8'h00;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_req = 1'b0;
		frame_left = 0;
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed, reset config ---
		// every stuffed value in the payload, data extremes
		send_payload(8'h00, 1'b0);
		send_payload(8'hFF, 1'b0);
		send_payload(8'h7E, 1'b0);
		send_payload(8'h7D, 1'b0);
		send_payload(8'h5D, 1'b1);
		// payload check lands on the flag value
		send_payload(8'h7C, 1'b0);
		send_payload(8'h02, 1'b1);
		// single-byte frame
		send_payload(8'hAA, 1'b1);
		// register write in the middle of a frame
		send_payload(8'h11, 1'b0);
		wait_drain();
		write_reg(CFG_FLAG, 8'h11);
		send_payload(8'h11, 1'b1);
		wait_drain();

		// header, data and check all stuffed: twelve words from one payload word
		set_config(8'h00, 8'h20, 8'h00, 1'b1);
		send_payload(8'h00, 1'b1);
		send_payload(8'h20, 1'b0);
		send_payload(8'h00, 1'b1);
		wait_drain();

		// flag equal to escape
		set_config(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_payload(8'hFF, 1'b0);
		send_payload(8'h00, 1'b1);
		wait_drain();

		set_config(8'hFF, 8'h00, 8'h00, 1'b0);
		send_payload(8'h00, 1'b0);
		send_payload(8'h80, 1'b0);
		send_payload(8'h01, 1'b1);
		wait_drain();

		// --- random phases, one config flavor each ---
		for (int ph = 0; ph < 6; ph++) begin
			r = 8'($urandom);
			case (ph)
				0: set_config(8'h7E, 8'h7D, 8'h03, 1'b0);
				1: set_config(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
				2: set_config(8'h00, 8'hFF, 8'h00, 1'b1);
				3: set_config(r, r, 8'($urandom), 1'($urandom));
				4: set_config(8'hFF, 8'h00, 8'hFF, 1'b0);
				default: set_config(r, 8'($urandom), r, 1'($urandom));
			endcase
			send_idle = (ph != 2 && ph != 4);
			recv_idle = (ph != 4);
			// back-to-back offers against a stalled line side
			if (ph == 2)
				hold_req = 1'b1;
			send_frames(40);
			wait_drain();
		end

		repeat (20) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d line words never arrived", sb.expected_q.size()));
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
